### rtl/lsa_pkg.sv
`default_nettype none
package lsa_pkg;

    localparam int MAX_LEN = 1024;
    localparam int GENE_W  = 16;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = 11;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [CNT_W-1:0] MAX_LEN_C = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] CNT_SAT   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MAXSEG_RST = CNT_W'(1024);

    typedef enum logic [1:0] {
        KIND_TARGET = 2'd0,
        KIND_BASE   = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    typedef enum logic {
        REG_SUBSTR = 1'b0,
        REG_MAXSEG = 1'b1
    } t_reg;

    typedef struct packed {
        logic             has_segment;
        logic [CNT_W-1:0] seg_start;
        logic [CNT_W-1:0] seg_end;
        logic             done_res;
        logic             not_subsequence;
        logic [CNT_W-1:0] segment_total;
    } t_result;

endpackage
`default_nettype wire

### rtl/lost_segment_aligner.sv
// One transaction per cycle unless the queue is full; a result enters
// the queue on acceptance. The target gene read for the next base gene
// is issued from the next target index in the same cycle.
// A two-entry result queue keeps input flowing while a result waits.
// Reset: synchronous, active low; clears run state and registers, the
// target store is not cleared and holds undefined data until written.
`default_nettype none
module lost_segment_aligner (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_kind,
    input  wire logic [lsa_pkg::GENE_W-1:0] i_gene_id,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_has_segment,
    output logic      [lsa_pkg::CNT_W-1:0]  o_seg_start,
    output logic      [lsa_pkg::CNT_W-1:0]  o_seg_end,
    output logic                            o_done_res,
    output logic                            o_not_subsequence,
    output logic      [lsa_pkg::CNT_W-1:0]  o_segment_total,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lsa_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lsa_pkg::DATA_W-1:0] pwdata,
    output logic      [lsa_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import lsa_pkg::*;

    logic             r_substr;
    logic [CNT_W-1:0] r_maxseg;

    logic [CNT_W-1:0] r_tl, n_tl;
    logic [CNT_W-1:0] r_ti, n_ti;
    logic [CNT_W-1:0] r_bi, n_bi;
    logic             r_aligned, n_aligned;
    logic [CNT_W-1:0] r_run_start, n_run_start;
    logic [CNT_W-1:0] r_seg_cnt, n_seg_cnt;
    logic             r_stopped, n_stopped;
    logic [CNT_W-1:0] r_stop_pos, n_stop_pos;

    logic              w_acc;
    logic              w_wr_en;
    logic [GENE_W-1:0] w_tgt;
    logic              w_full;
    logic              w_push;
    t_result           w_res;
    t_result           w_out;
    t_reg              w_reg;

    assign pready     = 1'b1;
    assign w_reg      = t_reg'(paddr[2]);
    assign o_in_ready = !w_full;
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        unique case (w_reg)
            REG_SUBSTR: prdata = {{(DATA_W-1){1'b0}}, r_substr};
            REG_MAXSEG: prdata = {{(DATA_W-CNT_W){1'b0}}, r_maxseg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_substr <= 1'b0;
            r_maxseg <= MAXSEG_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg)
                REG_SUBSTR: r_substr <= pwdata[0];
                REG_MAXSEG: r_maxseg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_tl        = r_tl;
        n_ti        = r_ti;
        n_bi        = r_bi;
        n_aligned   = r_aligned;
        n_run_start = r_run_start;
        n_seg_cnt   = r_seg_cnt;
        n_stopped   = r_stopped;
        n_stop_pos  = r_stop_pos;
        w_wr_en     = 1'b0;
        w_push      = 1'b0;
        w_res       = '0;
        if (w_acc) begin
            unique case (i_kind)
                KIND_TARGET: begin
                    if (r_tl < MAX_LEN_C) begin
                        w_wr_en = 1'b1;
                        n_tl    = r_tl + 1'b1;
                    end
                end
                KIND_BASE: begin
                    if (r_bi < MAX_LEN_C) begin
                        n_bi = r_bi + 1'b1;
                        if (!r_stopped) begin
                            if (r_seg_cnt >= r_maxseg || r_ti >= r_tl) begin
                                n_stopped  = 1'b1;
                                n_stop_pos = r_bi;
                            end else if (i_gene_id != w_tgt) begin
                                if (r_aligned) begin
                                    n_aligned   = 1'b0;
                                    n_run_start = r_bi;
                                end
                            end else begin
                                n_ti = r_ti + 1'b1;
                                if (!r_aligned) begin
                                    n_aligned = 1'b1;
                                    if (!r_substr || r_run_start != '0) begin
                                        if (r_seg_cnt != CNT_SAT) begin
                                            n_seg_cnt = r_seg_cnt + 1'b1;
                                        end
                                        w_push              = 1'b1;
                                        w_res.has_segment   = 1'b1;
                                        w_res.seg_start     = r_run_start;
                                        w_res.seg_end       = r_bi;
                                        w_res.segment_total = n_seg_cnt;
                                    end
                                    if (n_seg_cnt >= r_maxseg) begin
                                        n_stopped  = 1'b1;
                                        n_stop_pos = r_bi;
                                        n_ti       = r_ti;
                                    end
                                end
                            end
                        end
                    end
                end
                KIND_FINISH: begin
                    w_push         = 1'b1;
                    w_res.done_res = 1'b1;
                    if (!r_stopped) begin
                        w_res.not_subsequence = (r_ti < r_tl);
                    end else if (r_ti >= r_tl && !r_substr) begin
                        if (r_seg_cnt != CNT_SAT) begin
                            n_seg_cnt = r_seg_cnt + 1'b1;
                        end
                        w_res.has_segment = 1'b1;
                        w_res.seg_start   = r_stop_pos;
                        w_res.seg_end     = r_bi;
                    end
                    w_res.segment_total = n_seg_cnt;
                    n_tl        = '0;
                    n_ti        = '0;
                    n_bi        = '0;
                    n_aligned   = 1'b1;
                    n_run_start = '0;
                    n_seg_cnt   = '0;
                    n_stopped   = 1'b0;
                    n_stop_pos  = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl        <= '0;
            r_ti        <= '0;
            r_bi        <= '0;
            r_aligned   <= 1'b1;
            r_run_start <= '0;
            r_seg_cnt   <= '0;
            r_stopped   <= 1'b0;
            r_stop_pos  <= '0;
        end else begin
            r_tl        <= n_tl;
            r_ti        <= n_ti;
            r_bi        <= n_bi;
            r_aligned   <= n_aligned;
            r_run_start <= n_run_start;
            r_seg_cnt   <= n_seg_cnt;
            r_stopped   <= n_stopped;
            r_stop_pos  <= n_stop_pos;
        end
    end

    lsa_target_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tl[IDX_W-1:0]),
        .i_wr_data (i_gene_id),
        .i_rd_addr (n_ti[IDX_W-1:0]),
        .o_rd_data (w_tgt)
    );

    lsa_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_out)
    );

    assign o_has_segment     = w_out.has_segment;
    assign o_seg_start       = w_out.seg_start;
    assign o_seg_end         = w_out.seg_end;
    assign o_done_res        = w_out.done_res;
    assign o_not_subsequence = w_out.not_subsequence;
    assign o_segment_total   = w_out.segment_total;

endmodule
`default_nettype wire

### rtl/lsa_target_ram.sv
`default_nettype none
module lsa_target_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [lsa_pkg::IDX_W-1:0]  i_wr_addr,
    input  wire logic [lsa_pkg::GENE_W-1:0] i_wr_data,
    input  wire logic [lsa_pkg::IDX_W-1:0]  i_rd_addr,
    output logic      [lsa_pkg::GENE_W-1:0] o_rd_data
);
    import lsa_pkg::*;

    logic [GENE_W-1:0] r_mem [MAX_LEN];
    logic [GENE_W-1:0] r_rd_data;
    logic [GENE_W-1:0] r_fwd_data;
    logic              r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
        r_fwd_data <= i_wr_data;
    end

    // bypass a write that landed on the entry being read
    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule
`default_nettype wire

### rtl/lsa_out_q.sv
`default_nettype none
module lsa_out_q (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lsa_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output lsa_pkg::t_result      o_data
);
    import lsa_pkg::*;

    t_result    r_q [2];
    logic       r_head;
    logic [1:0] r_count;
    logic       n_head;
    logic [1:0] n_count;
    logic       w_pop;
    logic       w_tail;

    assign w_pop   = o_valid && i_ready;
    assign w_tail  = r_head ^ r_count[0];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_q[r_head];

    always_comb begin
        n_head  = r_head ^ w_pop;
        n_count = r_count + 2'(i_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
        if (i_push) begin
            r_q[w_tail] <= i_data;
        end
    end

endmodule
`default_nettype wire

### bench/tb_lost_segment_aligner.sv
`timescale 1ns / 100ps
module tb_lost_segment_aligner;
    import lsa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 600;
    localparam int PRINT_CAP = 30;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [GENE_W-1:0] gene;
    } t_gene_item;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_kind = '0;
    logic [GENE_W-1:0]   i_gene_id = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_has_segment;
    logic [CNT_W-1:0]    o_seg_start;
    logic [CNT_W-1:0]    o_seg_end;
    logic                o_done_res;
    logic                o_not_subsequence;
    logic [CNT_W-1:0]    o_segment_total;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    lost_segment_aligner u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_gene_id         (i_gene_id),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_has_segment     (o_has_segment),
        .o_seg_start       (o_seg_start),
        .o_seg_end         (o_seg_end),
        .o_done_res        (o_done_res),
        .o_not_subsequence (o_not_subsequence),
        .o_segment_total   (o_segment_total),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // aligner mirror state
    logic [GENE_W-1:0] tgt_genes [MAX_LEN];
    logic [CNT_W-1:0]  tgt_len;
    logic [CNT_W-1:0]  tgt_pos;
    logic [CNT_W-1:0]  base_pos;
    logic [CNT_W-1:0]  run_begin;
    logic [CNT_W-1:0]  seg_count;
    logic [CNT_W-1:0]  stop_at;
    logic              in_match;
    logic              halted;
    logic              substr_mode;
    logic [CNT_W-1:0]  seg_limit;

    t_gene_item pending_items [$];
    t_result    expected_results [$];

    int  n_queued = 0;
    int  n_counted = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  n_segments = 0;
    int  n_not_subseq = 0;
    int  n_errors = 0;
    int  cycle_cnt = 0;
    bit  in_fire = 1'b0;
    bit  calm = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("ERROR t=%0t result %0d %s: got %0d expected %0d",
                     $time, n_checked, what, got, want);
    endtask

    function automatic void clear_run();
        tgt_len   = '0;
        tgt_pos   = '0;
        base_pos  = '0;
        in_match  = 1'b1;
        run_begin = '0;
        seg_count = '0;
        halted    = 1'b0;
        stop_at   = '0;
    endfunction

    function automatic void bump_segments();
        if (seg_count != CNT_SAT)
            seg_count = seg_count + 1'b1;
    endfunction

    function automatic void push_result(input logic seg, input logic [CNT_W-1:0] s,
                                        input logic [CNT_W-1:0] e, input logic done,
                                        input logic bad);
        t_result r;
        r.has_segment     = seg;
        r.seg_start       = seg ? s : '0;
        r.seg_end         = seg ? e : '0;
        r.done_res        = done;
        r.not_subsequence = bad;
        r.segment_total   = seg_count;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void align_step(input logic [1:0] kind, input logic [GENE_W-1:0] gene);
        logic [CNT_W-1:0] pos;
        logic             stop_now;
        logic             seg;
        logic             bad;
        case (kind)
            KIND_TARGET: begin
                if (tgt_len < MAX_LEN_C) begin
                    tgt_genes[tgt_len[IDX_W-1:0]] = gene;
                    tgt_len = tgt_len + 1'b1;
                end
            end
            KIND_BASE: begin
                if (base_pos < MAX_LEN_C) begin
                    pos = base_pos;
                    base_pos = base_pos + 1'b1;
                    if (!halted) begin
                        if (seg_count >= seg_limit || tgt_pos >= tgt_len) begin
                            halted  = 1'b1;
                            stop_at = pos;
                        end else if (gene != tgt_genes[tgt_pos[IDX_W-1:0]]) begin
                            if (in_match) begin
                                in_match  = 1'b0;
                                run_begin = pos;
                            end
                        end else begin
                            stop_now = 1'b0;
                            if (!in_match) begin
                                in_match = 1'b1;
                                if (!substr_mode || run_begin != 0) begin
                                    bump_segments();
                                    push_result(1'b1, run_begin, pos, 1'b0, 1'b0);
                                end
                                if (seg_count >= seg_limit) begin
                                    halted   = 1'b1;
                                    stop_at  = pos;
                                    stop_now = 1'b1;
                                end
                            end
                            if (!stop_now)
                                tgt_pos = tgt_pos + 1'b1;
                        end
                    end
                end
            end
            KIND_FINISH: begin
                seg = 1'b0;
                bad = 1'b0;
                if (!halted) begin
                    bad = tgt_pos < tgt_len;
                end else if (tgt_pos >= tgt_len && !substr_mode) begin
                    seg = 1'b1;
                    bump_segments();
                end
                push_result(seg, stop_at, base_pos, 1'b1, bad);
                clear_run();
            end
            default: ;
        endcase
    endfunction

    task automatic queue_item(input logic [1:0] kind, input logic [GENE_W-1:0] gene);
        t_gene_item it;
        it.kind = kind;
        it.gene = gene;
        pending_items.insert(pending_items.size(), it);
        n_queued++;
        if (kind != KIND_UNUSED)
            n_counted++;
    endtask

    task automatic settle();
        while (n_accepted != n_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg which, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            REG_SUBSTR: substr_mode = value[0];
            REG_MAXSEG: seg_limit = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_run(input int tlen, input bit close_run);
        logic [GENE_W-1:0] alph [4];
        logic [GENE_W-1:0] tgt [$];
        int k;
        int j;
        int extra;
        for (k = 0; k < 4; k++)
            alph[k] = GENE_W'($urandom);
        for (k = 0; k < tlen; k++) begin
            tgt.insert(tgt.size(), alph[$urandom_range(3)]);
            queue_item(KIND_TARGET, tgt[k]);
        end
        for (k = 0; k < tlen; k++) begin
            if ($urandom_range(99) < 30) begin
                extra = $urandom_range(1, 3);
                for (j = 0; j < extra; j++)
                    queue_item(KIND_BASE, alph[$urandom_range(3)]);
            end
            if ($urandom_range(99) < 4)
                queue_item(KIND_UNUSED, GENE_W'($urandom));
            if ($urandom_range(99) < 3)
                queue_item(KIND_TARGET, alph[$urandom_range(3)]);
            if ($urandom_range(99) >= 5)
                queue_item(KIND_BASE, tgt[k]);
        end
        if ($urandom_range(99) < 40) begin
            extra = $urandom_range(1, 4);
            for (j = 0; j < extra; j++)
                queue_item(KIND_BASE, alph[$urandom_range(3)]);
        end
        if (close_run)
            queue_item(KIND_FINISH, GENE_W'($urandom));
    endtask

    task automatic queue_long_runs();
        logic [GENE_W-1:0] tgt [$];
        int k;
        // fill target and base past capacity
        for (k = 0; k < MAX_LEN + 2; k++) begin
            tgt.insert(tgt.size(), GENE_W'($urandom));
            queue_item(KIND_TARGET, tgt[k]);
        end
        for (k = 0; k < MAX_LEN + 2; k++)
            queue_item(KIND_BASE, tgt[k]);
        queue_item(KIND_FINISH, '0);
        // short target, scattered losses, trailing run up to the base limit
        tgt.delete();
        for (k = 0; k < 300; k++) begin
            tgt.insert(tgt.size(), GENE_W'($urandom));
            queue_item(KIND_TARGET, tgt[k]);
        end
        for (k = 0; k < 300; k++) begin
            if ($urandom_range(1) == 1)
                queue_item(KIND_BASE, GENE_W'($urandom));
            queue_item(KIND_BASE, tgt[k]);
        end
        for (k = 0; k < 700; k++)
            queue_item(KIND_BASE, GENE_W'($urandom));
        queue_item(KIND_FINISH, '1);
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb_lost_segment_aligner NOT OK");
            $finish;
        end
    end

    // drive transactions and output backpressure
    always @(negedge i_clk) begin : drive
        t_gene_item it;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || in_fire) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
                    it = pending_items[0];
                    pending_items.delete(0);
                    i_in_valid <= 1'b1;
                    i_kind     <= it.kind;
                    i_gene_id  <= it.gene;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= calm || $urandom_range(99) >= 12;
        end
    end

    // observe transactions, predict and check
    always @(posedge i_clk) begin : observe
        t_result want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (o_has_segment !== want.has_segment)
                        report_mismatch("has_segment", o_has_segment, want.has_segment);
                    if (o_seg_start !== want.seg_start)
                        report_mismatch("seg_start", o_seg_start, want.seg_start);
                    if (o_seg_end !== want.seg_end)
                        report_mismatch("seg_end", o_seg_end, want.seg_end);
                    if (o_done_res !== want.done_res)
                        report_mismatch("done_res", o_done_res, want.done_res);
                    if (o_not_subsequence !== want.not_subsequence)
                        report_mismatch("not_subsequence", o_not_subsequence,
                                        want.not_subsequence);
                    if (o_segment_total !== want.segment_total)
                        report_mismatch("segment_total", o_segment_total, want.segment_total);
                    if (want.has_segment)
                        n_segments++;
                    if (want.not_subsequence)
                        n_not_subseq++;
                end
                n_checked++;
            end
            if (i_in_valid && o_in_ready) begin
                align_step(i_kind, i_gene_id);
                n_accepted++;
            end
        end
    end

    initial begin : stimulus
        int start_count;
        int tlen;
        clear_run();
        substr_mode = 1'b0;
        seg_limit   = MAXSEG_RST;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, lost run at start, stop on exhausted target, trailing run
        queue_item(KIND_TARGET, 16'h0000);
        queue_item(KIND_TARGET, 16'hFFFF);
        queue_item(KIND_BASE, 16'h1234);
        queue_item(KIND_BASE, 16'h0000);
        queue_item(KIND_BASE, 16'hFFFF);
        queue_item(KIND_BASE, 16'h5555);
        queue_item(KIND_UNUSED, 16'hFFFF);
        queue_item(KIND_FINISH, 16'h0000);
        // target not a subsequence, then finish with nothing loaded
        queue_item(KIND_TARGET, 16'hAAAA);
        queue_item(KIND_BASE, 16'h5555);
        queue_item(KIND_FINISH, 16'hFFFF);
        queue_item(KIND_FINISH, 16'h0000);
        settle();

        // substring mode drops leading and trailing runs
        apb_write(REG_SUBSTR, 32'd1);
        queue_item(KIND_TARGET, 16'd7);
        queue_item(KIND_BASE, 16'd1);
        queue_item(KIND_BASE, 16'd7);
        queue_item(KIND_BASE, 16'd2);
        queue_item(KIND_FINISH, 16'd0);
        settle();

        // zero segment limit stops at once
        apb_write(REG_MAXSEG, 32'd0);
        queue_item(KIND_TARGET, 16'd1);
        queue_item(KIND_BASE, 16'd1);
        queue_item(KIND_FINISH, 16'd0);
        settle();

        // limit reached mid-target, later base genes only advance
        apb_write(REG_SUBSTR, 32'd0);
        apb_write(REG_MAXSEG, 32'd1);
        queue_item(KIND_TARGET, 16'd3);
        queue_item(KIND_TARGET, 16'd4);
        queue_item(KIND_BASE, 16'd9);
        queue_item(KIND_BASE, 16'd3);
        queue_item(KIND_BASE, 16'd9);
        queue_item(KIND_BASE, 16'd4);
        queue_item(KIND_FINISH, 16'd0);
        settle();

        // full target and base stores, no idling
        apb_write(REG_MAXSEG, 32'd1024);
        calm = 1'b1;
        queue_long_runs();
        settle();
        calm = 1'b0;

        start_count = n_counted;
        while (n_counted - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(5) == 0) begin
                settle();
                apb_write(REG_SUBSTR, 32'($urandom_range(1)));
                case ($urandom_range(5))
                    0: apb_write(REG_MAXSEG, 32'd0);
                    1: apb_write(REG_MAXSEG, 32'd1);
                    2: apb_write(REG_MAXSEG, 32'd2);
                    3: apb_write(REG_MAXSEG, 32'd3);
                    4: apb_write(REG_MAXSEG, 32'($urandom_range(0, 1024)));
                    default: apb_write(REG_MAXSEG, 32'd1024);
                endcase
            end else if ($urandom_range(7) == 0) begin
                settle();
            end
            tlen = ($urandom_range(9) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
            queue_run(tlen, $urandom_range(99) < 92);
        end
        queue_item(KIND_FINISH, '0);
        settle();
        repeat (10) @(posedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 0, expected_results.size());
        $display("covered %0d transactions over several register settings, %0d results checked",
                 n_accepted, n_checked);
        $display("%0d lost segments, %0d runs where the target was not a subsequence",
                 n_segments, n_not_subseq);
        if (n_errors == 0)
            $display("tb_lost_segment_aligner OK");
        else
            $display("tb_lost_segment_aligner NOT OK");
        $finish;
    end

endmodule
